@@ src/sconv_pkg.sv @@
// constants, codes and shared types of the streaming 2-d convolution block
// no dependencies; used by every other file but sconv_ram through scoped names
package sconv_pkg;

    localparam int IMG_SIZE   = 32;
    localparam int CHANNELS   = 3;
    localparam int KERNEL     = 3;
    localparam int FILTERS    = 8;

    localparam int DATA_W     = 24;
    localparam int FRAC_W     = 20;
    localparam int ACT_W      = DATA_W - 1;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 8;
    localparam int FILT_W     = 3;
    localparam int POS_W      = 5;

    localparam int ROW_STRIDE = IMG_SIZE * CHANNELS;
    localparam int KC         = KERNEL * CHANNELS;
    localparam int WIN_DEPTH  = ROW_STRIDE * (KERNEL - 1) + KC;
    localparam int W_DEPTH    = KC * KERNEL * FILTERS;
    localparam int ROW_JUMP   = ROW_STRIDE - KC + 1;

    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int W_AW       = $clog2(W_DEPTH);
    localparam int ROW_W      = $clog2(IMG_SIZE);
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int KR_W       = $clog2(KERNEL);
    localparam int KC_W       = $clog2(KC);

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL  = 2'd0,
        CMD_WEIGHT = 2'd1,
        CMD_BIAS   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // control flags for each operand pair from the sequencer to the mac
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_op_t;

endpackage

@@ src/sconv_if.sv @@
// valid/ready channel interfaces for input items and result items
// depends on sconv_pkg
interface sconv_in_if;
    logic                                valid;
    logic                                ready;
    logic [sconv_pkg::CMD_W-1:0]         command;
    logic signed [sconv_pkg::DATA_W-1:0] sample;
    logic [sconv_pkg::IDX_W-1:0]         index;

    modport source (output valid, command, sample, index, input ready);
    modport sink (input valid, command, sample, index, output ready);
endinterface

interface sconv_out_if;
    logic                         valid;
    logic                         ready;
    logic [sconv_pkg::ACT_W-1:0]  activation;
    logic [sconv_pkg::FILT_W-1:0] filter_number;
    logic [sconv_pkg::POS_W-1:0]  out_row;
    logic [sconv_pkg::POS_W-1:0]  out_col;
    logic                         last;

    modport source (output valid, activation, filter_number, out_row, out_col, last,
                    input ready);
    modport sink (input valid, activation, filter_number, out_row, out_col, last,
                  output ready);
endinterface

@@ src/sconv_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module sconv_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sconv_mac.sv @@
// shared multiply-accumulate unit: registered product, wrapping 24-bit sum,
// bias add and relu; depends on sconv_pkg
module sconv_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sconv_pkg::mac_op_t                  op,
    input  logic signed [sconv_pkg::DATA_W-1:0] pixel,
    input  logic signed [sconv_pkg::DATA_W-1:0] weight,
    input  logic [sconv_pkg::DATA_W-1:0]        bias,
    output logic                                done,
    output logic [sconv_pkg::ACT_W-1:0]         activation
);

    logic signed [2*sconv_pkg::DATA_W-1:0] prod_reg;
    logic                                  prod_valid_reg;
    logic                                  prod_last_reg;
    logic                                  done_reg;
    logic [sconv_pkg::DATA_W-1:0]          acc_reg;
    logic [sconv_pkg::DATA_W-1:0]          acc_next;
    logic [sconv_pkg::DATA_W-1:0]          sum;

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg <= pixel * weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= op.valid;
            prod_last_reg  <= op.valid && op.last;
            done_reg       <= prod_valid_reg && prod_last_reg;
        end
    end

    // product floored to 20 fraction bits, sum wraps at 24 bits
    always_comb
    begin
        acc_next = acc_reg;
        if (op.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg
                + prod_reg[sconv_pkg::FRAC_W+sconv_pkg::DATA_W-1:sconv_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign sum        = acc_reg + bias;
    assign activation = sum[sconv_pkg::DATA_W-1] ? '0 : sum[sconv_pkg::ACT_W-1:0];
    assign done       = done_reg;

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        op.clear |-> (!prod_valid_reg && !op.valid))
        else $error("accumulator cleared while products are in flight");

    a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(prod_valid_reg && prod_last_reg))
        else $error("done raised without a last product");

endmodule

@@ src/sconv_ctrl.sv @@
// sequencer: raster position, window write pointer, operand address walk per
// filter, bias registers and result register; depends on sconv_pkg, sconv_if
module sconv_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    sconv_in_if.sink                          item,
    sconv_out_if.source                       result,
    output logic                              win_wr_en,
    output logic [sconv_pkg::WIN_AW-1:0]      win_wr_addr,
    output logic [sconv_pkg::WIN_AW-1:0]      win_rd_addr,
    output logic                              w_wr_en,
    output logic [sconv_pkg::W_AW-1:0]        w_wr_addr,
    output logic [sconv_pkg::W_AW-1:0]        w_rd_addr,
    output logic                              rd_en,
    output sconv_pkg::mac_op_t                mac_op,
    output logic [sconv_pkg::DATA_W-1:0]      bias,
    input  logic                              mac_done,
    input  logic [sconv_pkg::ACT_W-1:0]       mac_act
);

    sconv_pkg::state_t             state_reg, state_next;
    logic [sconv_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [sconv_pkg::ROW_W-1:0]   col_reg, col_next;
    logic [sconv_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic [sconv_pkg::WIN_AW-1:0]  wp_reg, wp_next;
    logic [sconv_pkg::WIN_AW-1:0]  base_reg, base_next;
    logic [sconv_pkg::WIN_AW-1:0]  win_addr_reg, win_addr_next;
    logic [sconv_pkg::W_AW-1:0]    w_addr_reg, w_addr_next;
    logic [sconv_pkg::FILT_W-1:0]  filt_reg, filt_next;
    logic [sconv_pkg::KR_W-1:0]    kr_reg, kr_next;
    logic [sconv_pkg::KC_W-1:0]    kc_reg, kc_next;
    logic                          issue_valid_reg, issue_valid_next;
    logic                          issue_last_reg, issue_last_next;
    logic [sconv_pkg::POS_W-1:0]   orow_reg, orow_next;
    logic [sconv_pkg::POS_W-1:0]   ocol_reg, ocol_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sconv_pkg::ACT_W-1:0]   out_act_reg, out_act_next;
    logic [sconv_pkg::FILT_W-1:0]  out_filt_reg, out_filt_next;
    logic [sconv_pkg::POS_W-1:0]   out_row_reg, out_row_next;
    logic [sconv_pkg::POS_W-1:0]   out_col_reg, out_col_next;
    logic                          out_last_reg, out_last_next;
    logic [sconv_pkg::DATA_W-1:0]  bias_reg [sconv_pkg::FILTERS];

    sconv_pkg::cmd_t               cmd;
    logic                          accept;
    logic                          emit;
    logic                          issue_end;
    logic                          filt_last;
    logic                          out_free;
    logic [sconv_pkg::WIN_AW-1:0]  wp_inc;
    logic [sconv_pkg::WIN_AW:0]    win_sum;
    logic [sconv_pkg::WIN_AW:0]    win_step;

    assign cmd       = sconv_pkg::cmd_t'(item.command);
    assign accept    = item.valid && item.ready;
    assign emit      = (ch_reg == sconv_pkg::CH_W'(sconv_pkg::CHANNELS - 1))
                    && (row_reg >= sconv_pkg::ROW_W'(sconv_pkg::KERNEL - 1))
                    && (col_reg >= sconv_pkg::ROW_W'(sconv_pkg::KERNEL - 1));
    assign issue_end = (kr_reg == sconv_pkg::KR_W'(sconv_pkg::KERNEL - 1))
                    && (kc_reg == sconv_pkg::KC_W'(sconv_pkg::KC - 1));
    assign filt_last = filt_reg == sconv_pkg::FILT_W'(sconv_pkg::FILTERS - 1);
    assign out_free  = !out_valid_reg || result.ready;
    assign wp_inc    = (wp_reg == sconv_pkg::WIN_AW'(sconv_pkg::WIN_DEPTH - 1))
                     ? '0 : wp_reg + 1'b1;

    // next window address: one step along a kernel row, or a jump to the next row
    assign win_step = (kc_reg == sconv_pkg::KC_W'(sconv_pkg::KC - 1))
                    ? (sconv_pkg::WIN_AW+1)'(sconv_pkg::ROW_JUMP)
                    : (sconv_pkg::WIN_AW+1)'(1);
    assign win_sum  = {1'b0, win_addr_reg} + win_step;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sconv_pkg::ST_IDLE:
            begin
                if (accept && cmd == sconv_pkg::CMD_PIXEL && emit)
                begin
                    state_next = sconv_pkg::ST_ISSUE;
                end
            end
            sconv_pkg::ST_ISSUE:
            begin
                if (issue_end)
                begin
                    state_next = sconv_pkg::ST_WAIT;
                end
            end
            sconv_pkg::ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = sconv_pkg::ST_EMIT;
                end
            end
            sconv_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = filt_last ? sconv_pkg::ST_IDLE : sconv_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = sconv_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item.ready   = state_reg == sconv_pkg::ST_IDLE;
        win_wr_en    = accept && cmd == sconv_pkg::CMD_PIXEL;
        win_wr_addr  = wp_reg;
        win_rd_addr  = win_addr_reg;
        w_wr_en      = accept && cmd == sconv_pkg::CMD_WEIGHT
                    && item.index < sconv_pkg::IDX_W'(sconv_pkg::W_DEPTH);
        w_wr_addr    = sconv_pkg::W_AW'(item.index);
        w_rd_addr    = w_addr_reg;
        rd_en        = state_reg == sconv_pkg::ST_ISSUE;
        mac_op.clear = state_next == sconv_pkg::ST_ISSUE
                    && state_reg != sconv_pkg::ST_ISSUE;
        mac_op.valid = issue_valid_reg;
        mac_op.last  = issue_last_reg;
        bias         = bias_reg[filt_reg];
    end

    // datapath next values
    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        ch_next          = ch_reg;
        wp_next          = wp_reg;
        base_next        = base_reg;
        win_addr_next    = win_addr_reg;
        w_addr_next      = w_addr_reg;
        filt_next        = filt_reg;
        kr_next          = kr_reg;
        kc_next          = kc_reg;
        orow_next        = orow_reg;
        ocol_next        = ocol_reg;
        out_act_next     = out_act_reg;
        out_filt_next    = out_filt_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        issue_valid_next = state_reg == sconv_pkg::ST_ISSUE;
        issue_last_next  = state_reg == sconv_pkg::ST_ISSUE && issue_end;

        case (state_reg)
            sconv_pkg::ST_IDLE:
            begin
                if (accept && cmd == sconv_pkg::CMD_PIXEL)
                begin
                    wp_next   = wp_inc;
                    base_next = wp_inc;
                    if (ch_reg == sconv_pkg::CH_W'(sconv_pkg::CHANNELS - 1))
                    begin
                        ch_next = '0;
                        if (col_reg == sconv_pkg::ROW_W'(sconv_pkg::IMG_SIZE - 1))
                        begin
                            col_next = '0;
                            row_next = (row_reg == sconv_pkg::ROW_W'(sconv_pkg::IMG_SIZE - 1))
                                     ? '0 : row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                    if (emit)
                    begin
                        orow_next     = sconv_pkg::POS_W'(row_reg
                                      - sconv_pkg::ROW_W'(sconv_pkg::KERNEL - 1));
                        ocol_next     = sconv_pkg::POS_W'(col_reg
                                      - sconv_pkg::ROW_W'(sconv_pkg::KERNEL - 1));
                        filt_next     = '0;
                        kr_next       = '0;
                        kc_next       = '0;
                        win_addr_next = wp_inc;
                        w_addr_next   = '0;
                    end
                end
            end
            sconv_pkg::ST_ISSUE:
            begin
                win_addr_next = (win_sum >= (sconv_pkg::WIN_AW+1)'(sconv_pkg::WIN_DEPTH))
                    ? sconv_pkg::WIN_AW'(win_sum - (sconv_pkg::WIN_AW+1)'(sconv_pkg::WIN_DEPTH))
                    : sconv_pkg::WIN_AW'(win_sum);
                w_addr_next = w_addr_reg + sconv_pkg::W_AW'(sconv_pkg::FILTERS);
                if (kc_reg == sconv_pkg::KC_W'(sconv_pkg::KC - 1))
                begin
                    kc_next = '0;
                    kr_next = kr_reg + 1'b1;
                end
                else
                begin
                    kc_next = kc_reg + 1'b1;
                end
            end
            sconv_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = mac_act;
                    out_filt_next  = filt_reg;
                    out_row_next   = orow_reg;
                    out_col_next   = ocol_reg;
                    out_last_next  = filt_last;
                    if (!filt_last)
                    begin
                        filt_next     = filt_reg + 1'b1;
                        kr_next       = '0;
                        kc_next       = '0;
                        win_addr_next = base_reg;
                        w_addr_next   = sconv_pkg::W_AW'(filt_reg) + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sconv_pkg::ST_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            ch_reg          <= '0;
            wp_reg          <= '0;
            filt_reg        <= '0;
            kr_reg          <= '0;
            kc_reg          <= '0;
            issue_valid_reg <= 1'b0;
            issue_last_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            ch_reg          <= ch_next;
            wp_reg          <= wp_next;
            filt_reg        <= filt_next;
            kr_reg          <= kr_next;
            kc_reg          <= kc_next;
            issue_valid_reg <= issue_valid_next;
            issue_last_reg  <= issue_last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        win_addr_reg <= win_addr_next;
        w_addr_reg   <= w_addr_next;
        orow_reg     <= orow_next;
        ocol_reg     <= ocol_next;
        out_act_reg  <= out_act_next;
        out_filt_reg <= out_filt_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == sconv_pkg::CMD_BIAS
            && item.index < sconv_pkg::IDX_W'(sconv_pkg::FILTERS))
        begin
            bias_reg[item.index[sconv_pkg::FILT_W-1:0]] <= item.sample;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.activation    = out_act_reg;
    assign result.filter_number = out_filt_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.last          = out_last_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == sconv_pkg::ST_WAIT)
        else $error("mac finished outside the wait state");

    a_win_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sconv_pkg::ST_ISSUE
        |-> win_addr_reg < sconv_pkg::WIN_AW'(sconv_pkg::WIN_DEPTH))
        else $error("window read address beyond the store");

    a_last_ends_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sconv_pkg::ST_EMIT && out_free && filt_last)
        |=> (state_reg == sconv_pkg::ST_IDLE && result.valid && result.last))
        else $error("last filter result did not close the window");

endmodule

@@ src/streaming_conv2d_relu.sv @@
// top level of the streaming 2-d convolution with relu
// depends on sconv_pkg, sconv_if, sconv_ram, sconv_mac, sconv_ctrl
//
//   port     dir   beat contents
//   item     in    command, sample (Q4.20), index
//   result   out   activation (Q3.20), filter_number, out_row, out_col, last
//
// weight, bias, ignored and non-window pixel beats keep item.ready high, so
// the next beat can follow straight away; a pixel that completes a window
// holds item.ready low while the single mac runs 8 filters, each with 27
// operand reads, a wait for the mac pipeline and a result load; a stalled
// result stretches the load
// the result register lets the next item in while the last result waits
// reset clears position, pointers and handshake state; weights, biases and
// window samples hold no reset value until written
module streaming_conv2d_relu (
    input  logic        clk,
    input  logic        rst_n,
    sconv_in_if.sink    item,
    sconv_out_if.source result
);

    logic                             win_wr_en;
    logic [sconv_pkg::WIN_AW-1:0]     win_wr_addr;
    logic [sconv_pkg::WIN_AW-1:0]     win_rd_addr;
    logic                             w_wr_en;
    logic [sconv_pkg::W_AW-1:0]       w_wr_addr;
    logic [sconv_pkg::W_AW-1:0]       w_rd_addr;
    logic                             rd_en;
    sconv_pkg::mac_op_t               mac_op;
    logic [sconv_pkg::DATA_W-1:0]     bias;
    logic                             mac_done;
    logic [sconv_pkg::ACT_W-1:0]      mac_act;
    logic [sconv_pkg::DATA_W-1:0]     win_rd_data;
    logic [sconv_pkg::DATA_W-1:0]     w_rd_data;

    sconv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .win_wr_en   (win_wr_en),
        .win_wr_addr (win_wr_addr),
        .win_rd_addr (win_rd_addr),
        .w_wr_en     (w_wr_en),
        .w_wr_addr   (w_wr_addr),
        .w_rd_addr   (w_rd_addr),
        .rd_en       (rd_en),
        .mac_op      (mac_op),
        .bias        (bias),
        .mac_done    (mac_done),
        .mac_act     (mac_act)
    );

    // sliding window kept as a ring of the last samples
    sconv_ram #(
        .DEPTH  (sconv_pkg::WIN_DEPTH),
        .WIDTH  (sconv_pkg::DATA_W),
        .ADDR_W (sconv_pkg::WIN_AW)
    ) u_win_ram (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (item.sample),
        .rd_en   (rd_en),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    sconv_ram #(
        .DEPTH  (sconv_pkg::W_DEPTH),
        .WIDTH  (sconv_pkg::DATA_W),
        .ADDR_W (sconv_pkg::W_AW)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (item.sample),
        .rd_en   (rd_en),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    sconv_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (mac_op),
        .pixel      (win_rd_data),
        .weight     (w_rd_data),
        .bias       (bias),
        .done       (mac_done),
        .activation (mac_act)
    );

endmodule

@@ sim/tb.sv @@
// testbench for streaming_conv2d_relu: a directed stimulus table followed by a
// randomized weight, bias and pixel stream that reaches the first windows
// depends on sconv_pkg and sconv_if; results are checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int NUM_DIRECTED   = 16;
    // fills the window store, then the first windows of the third row
    localparam int PIXEL_BEATS    = sconv_pkg::ROW_STRIDE * (sconv_pkg::KERNEL - 1)
                                  + 8 * sconv_pkg::CHANNELS - 1;

    typedef struct packed {
        sconv_pkg::cmd_t              cmd;
        logic [sconv_pkg::DATA_W-1:0] value;
        logic [sconv_pkg::IDX_W-1:0]  idx;
        logic                         expect_none;
    } stim_row_t;

    typedef struct packed {
        logic [sconv_pkg::ACT_W-1:0]  activation;
        logic [sconv_pkg::FILT_W-1:0] filter_number;
        logic [sconv_pkg::POS_W-1:0]  out_row;
        logic [sconv_pkg::POS_W-1:0]  out_col;
        logic                         last;
    } conv_result_t;

    logic clk;
    logic rst_n;

    sconv_in_if  item_ch ();
    sconv_out_if result_ch ();

    streaming_conv2d_relu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predictor state
    logic signed [sconv_pkg::DATA_W-1:0] window_model [sconv_pkg::WIN_DEPTH];
    logic signed [sconv_pkg::DATA_W-1:0] weight_model [sconv_pkg::W_DEPTH];
    logic signed [sconv_pkg::DATA_W-1:0] bias_model [sconv_pkg::FILTERS];
    int unsigned                         px_row;
    int unsigned                         px_col;
    int unsigned                         px_chan;

    conv_result_t pending_activations [$];
    int unsigned  mismatch_count;
    int unsigned  burst_left;

    // no row here can complete a window: weights, biases, ignored commands and
    // the first few pixels of the window store
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{sconv_pkg::CMD_BIAS,   24'h000000, 8'd0,   1'b1},
        '{sconv_pkg::CMD_BIAS,   24'h7fffff, 8'd7,   1'b1},
        '{sconv_pkg::CMD_BIAS,   24'hffffff, 8'd8,   1'b1},
        '{sconv_pkg::CMD_BIAS,   24'h800000, 8'd255, 1'b1},
        '{sconv_pkg::CMD_WEIGHT, 24'h800000, 8'd0,   1'b1},
        '{sconv_pkg::CMD_WEIGHT, 24'h7fffff, 8'd215, 1'b1},
        '{sconv_pkg::CMD_WEIGHT, 24'h000001, 8'd216, 1'b1},
        '{sconv_pkg::CMD_WEIGHT, 24'hffffff, 8'd255, 1'b1},
        '{sconv_pkg::CMD_WEIGHT, 24'h555555, 8'd128, 1'b1},
        '{sconv_pkg::CMD_NONE,   24'h000000, 8'd0,   1'b1},
        '{sconv_pkg::CMD_NONE,   24'hffffff, 8'd255, 1'b1},
        '{sconv_pkg::CMD_PIXEL,  24'h800000, 8'd0,   1'b1},
        '{sconv_pkg::CMD_PIXEL,  24'h7fffff, 8'd255, 1'b1},
        '{sconv_pkg::CMD_PIXEL,  24'h000000, 8'd170, 1'b1},
        '{sconv_pkg::CMD_PIXEL,  24'haaaaaa, 8'd85,  1'b1},
        '{sconv_pkg::CMD_PIXEL,  24'h000001, 8'd0,   1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // updates the model with one accepted beat and queues the window results
    task automatic convolve_item(input sconv_pkg::cmd_t cmd,
                                 input logic [sconv_pkg::DATA_W-1:0] value,
                                 input logic [sconv_pkg::IDX_W-1:0] idx, input bit typed);
        logic signed [2*sconv_pkg::DATA_W-1:0] prod;
        logic [sconv_pkg::DATA_W-1:0]          acc;
        conv_result_t                          res;
        int                                    i, f, kr, kc, ch, wi, pi;
        case (cmd)
            sconv_pkg::CMD_WEIGHT:
                if (idx < sconv_pkg::W_DEPTH)
                    weight_model[idx] = value;
            sconv_pkg::CMD_BIAS:
                if (idx < sconv_pkg::FILTERS)
                    bias_model[idx] = value;
            sconv_pkg::CMD_PIXEL:
            begin
                for (i = 0; i < sconv_pkg::WIN_DEPTH - 1; i++)
                    window_model[i] = window_model[i+1];
                window_model[sconv_pkg::WIN_DEPTH-1] = value;
                if (!typed && px_chan == sconv_pkg::CHANNELS - 1
                    && px_row >= sconv_pkg::KERNEL - 1 && px_col >= sconv_pkg::KERNEL - 1)
                begin
                    for (f = 0; f < sconv_pkg::FILTERS; f++)
                    begin
                        acc = '0;
                        for (kr = 0; kr < sconv_pkg::KERNEL; kr++)
                            for (kc = 0; kc < sconv_pkg::KERNEL; kc++)
                                for (ch = 0; ch < sconv_pkg::CHANNELS; ch++)
                                begin
                                    wi = ((kr * sconv_pkg::KERNEL + kc) * sconv_pkg::CHANNELS
                                         + ch) * sconv_pkg::FILTERS + f;
                                    pi = kr * sconv_pkg::ROW_STRIDE
                                       + kc * sconv_pkg::CHANNELS + ch;
                                    prod = window_model[pi] * weight_model[wi];
                                    // floor to 20 fraction bits, wrap at 24
                                    acc = acc + prod[sconv_pkg::FRAC_W+sconv_pkg::DATA_W-1:
                                                     sconv_pkg::FRAC_W];
                                end
                        acc = acc + bias_model[f];
                        res.activation    = acc[sconv_pkg::DATA_W-1]
                                          ? '0 : acc[sconv_pkg::ACT_W-1:0];
                        res.filter_number = sconv_pkg::FILT_W'(f);
                        res.out_row       = sconv_pkg::POS_W'(px_row - (sconv_pkg::KERNEL - 1));
                        res.out_col       = sconv_pkg::POS_W'(px_col - (sconv_pkg::KERNEL - 1));
                        res.last          = (f == sconv_pkg::FILTERS - 1);
                        pending_activations.push_back(res);
                    end
                end
                if (px_chan + 1 >= sconv_pkg::CHANNELS)
                begin
                    px_chan = 0;
                    if (px_col + 1 >= sconv_pkg::IMG_SIZE)
                    begin
                        px_col = 0;
                        px_row = (px_row + 1 >= sconv_pkg::IMG_SIZE) ? 0 : px_row + 1;
                    end
                    else
                        px_col++;
                end
                else
                    px_chan++;
            end
            default: ;
        endcase
    endtask

    // one beat on the item channel, in bursts with random gaps between them
    task automatic send_item(input sconv_pkg::cmd_t cmd,
                             input logic [sconv_pkg::DATA_W-1:0] value,
                             input logic [sconv_pkg::IDX_W-1:0] idx, input bit typed);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.sample  <= value;
        item_ch.index   <= idx;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        convolve_item(cmd, value, idx, typed);
    endtask

    // mix of extremes, full-range and small magnitudes
    function automatic logic [sconv_pkg::DATA_W-1:0] pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'h000000;
            3, 4, 5: return raw[sconv_pkg::DATA_W-1:0];
            default: return {{(sconv_pkg::DATA_W-19){raw[18]}}, raw[18:0]};
        endcase
    endfunction

    // occasional ignored beats and harmless rewrites between regular beats
    task automatic maybe_noise();
        if ($urandom_range(0, 19) == 0)
        begin
            case ($urandom_range(0, 4))
                0: send_item(sconv_pkg::CMD_NONE, sconv_pkg::DATA_W'($urandom),
                             sconv_pkg::IDX_W'($urandom), 1'b0);
                1: send_item(sconv_pkg::CMD_WEIGHT, sconv_pkg::DATA_W'($urandom),
                             sconv_pkg::IDX_W'($urandom_range(sconv_pkg::W_DEPTH, 255)), 1'b0);
                2: send_item(sconv_pkg::CMD_BIAS, sconv_pkg::DATA_W'($urandom),
                             sconv_pkg::IDX_W'($urandom_range(sconv_pkg::FILTERS, 255)), 1'b0);
                3: send_item(sconv_pkg::CMD_WEIGHT, pick_value(),
                             sconv_pkg::IDX_W'($urandom_range(0, sconv_pkg::W_DEPTH - 1)), 1'b0);
                default: send_item(sconv_pkg::CMD_BIAS, pick_value(),
                             sconv_pkg::IDX_W'($urandom_range(0, sconv_pkg::FILTERS - 1)), 1'b0);
            endcase
        end
    endtask

    // receiver: switches at random between always ready, random ready and long stalls
    initial
    begin : result_sink
        int mode;
        int span;
        int hold;
        result_ch.ready = 1'b0;
        mode = 0;
        span = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(20, 200);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= $urandom_range(0, 1);
                    default:
                        if ($urandom_range(0, 3) == 0)
                        begin
                            hold = $urandom_range(1, 30);
                            result_ch.ready <= 1'b0;
                        end
                        else
                            result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_activations.size() == 0)
                flag_mismatch($sformatf("result with nothing pending: act %h filter %0d",
                                        result_ch.activation, result_ch.filter_number));
            else
            begin
                want = pending_activations.pop_front();
                if (result_ch.activation !== want.activation
                    || result_ch.filter_number !== want.filter_number
                    || result_ch.out_row !== want.out_row
                    || result_ch.out_col !== want.out_col
                    || result_ch.last !== want.last)
                    flag_mismatch($sformatf(
                        "got act %h f %0d r %0d c %0d l %b, want act %h f %0d r %0d c %0d l %b",
                        result_ch.activation, result_ch.filter_number, result_ch.out_row,
                        result_ch.out_col, result_ch.last, want.activation,
                        want.filter_number, want.out_row, want.out_col, want.last));
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("streaming_conv2d_relu regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int order [sconv_pkg::W_DEPTH];
        int i, j, tmp;
        item_ch.valid   = 1'b0;
        item_ch.command = sconv_pkg::CMD_PIXEL;
        item_ch.sample  = '0;
        item_ch.index   = '0;
        rst_n           = 1'b0;
        mismatch_count  = 0;
        burst_left      = 0;
        px_row          = 0;
        px_col          = 0;
        px_chan         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].idx,
                      directed_rows[i].expect_none);

        // every weight and bias is written before the first window completes
        for (i = 0; i < sconv_pkg::W_DEPTH; i++)
            order[i] = i;
        for (i = sconv_pkg::W_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < sconv_pkg::W_DEPTH; i++)
        begin
            maybe_noise();
            send_item(sconv_pkg::CMD_WEIGHT, pick_value(), sconv_pkg::IDX_W'(order[i]), 1'b0);
        end
        for (i = 0; i < sconv_pkg::FILTERS; i++)
        begin
            maybe_noise();
            send_item(sconv_pkg::CMD_BIAS, pick_value(), sconv_pkg::IDX_W'(i), 1'b0);
        end
        for (i = 0; i < PIXEL_BEATS; i++)
        begin
            maybe_noise();
            send_item(sconv_pkg::CMD_PIXEL, pick_value(), sconv_pkg::IDX_W'($urandom), 1'b0);
        end
        @(negedge clk);
        item_ch.valid <= 1'b0;

        while (pending_activations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_activations.size() == 0)
            $display("streaming_conv2d_relu regression: pass");
        else
            $display("streaming_conv2d_relu regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/sconv_pkg.sv
src/sconv_if.sv
src/sconv_ram.sv
src/sconv_mac.sv
src/sconv_ctrl.sv
src/streaming_conv2d_relu.sv
sim/tb.sv
